FILE: rtl/core/c8_pkg.sv
package c8_pkg;

  localparam int unsigned MEM_BYTES  = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned PC_W       = 13;
  localparam int unsigned SCREEN_W   = 64;
  localparam int unsigned SCREEN_H   = 32;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned STACK_DEPTH = 16;
  localparam logic [PC_W-1:0] START_ADDRESS = 13'd512;
  localparam logic [PC_W-1:0] PC_LAST       = 13'(MEM_BYTES - 2);

  // item operations
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_EXEC  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_ROW   = 3'd4;

  // halt causes
  localparam logic [1:0] HALT_RUN     = 2'd0;
  localparam logic [1:0] HALT_ILLEGAL = 2'd1;
  localparam logic [1:0] HALT_PC      = 2'd2;

  // instruction groups (top nibble)
  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JP   = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SEI  = 4'h3;
  localparam logic [3:0] G_SNEI = 4'h4;
  localparam logic [3:0] G_SER  = 4'h5;
  localparam logic [3:0] G_LDI  = 4'h6;
  localparam logic [3:0] G_ADDI = 4'h7;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_SNER = 4'h9;
  localparam logic [3:0] G_LDIX = 4'hA;
  localparam logic [3:0] G_JPV0 = 4'hB;
  localparam logic [3:0] G_RND  = 4'hC;
  localparam logic [3:0] G_DRW  = 4'hD;
  localparam logic [3:0] G_KEY  = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GETDT = 8'h07;
  localparam logic [7:0] KK_WAITK = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDIX = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
    logic [4:0]  display_row;
  } item_t;

  typedef struct packed {
    logic [12:0] program_counter;
    logic [15:0] last_opcode;
    logic [7:0]  read_byte;
    logic [63:0] row_pixels;
    logic        drew;
    logic        sound_on;
    logic [1:0]  halt_cause;
  } result_t;

  function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] s);
    logic [6:0] ls;
    ls = 7'd64 - {1'b0, s};
    return (v >> s) | (v << ls);
  endfunction

  // lowest pressed key
  function automatic logic [3:0] first_key(input logic [15:0] keys);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) k = 4'(i);
    end
    return k;
  endfunction

  // decimal digit sel of v: 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h) * 8'd100;
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 8'({t, 3'b000} + {t, 1'b0});
    case (sel)
      2'd0:    return {6'd0, h};
      2'd1:    return {4'd0, t};
      default: return o;
    endcase
  endfunction

endpackage

FILE: rtl/core/c8_ram.sv
module c8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    q <= mem[addr];
  end

endmodule

FILE: rtl/core/c8_exec.sv
module c8_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  c8_pkg::item_t    item,
  input  logic             ack,
  output logic             idle,
  output logic             done,
  output c8_pkg::result_t  result
);
  import c8_pkg::*;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_MRD  = 5'd2;
  localparam logic [4:0] S_FRD  = 5'd3;
  localparam logic [4:0] S_FH   = 5'd4;
  localparam logic [4:0] S_FL   = 5'd5;
  localparam logic [4:0] S_RX   = 5'd6;
  localparam logic [4:0] S_EX   = 5'd7;
  localparam logic [4:0] S_WF   = 5'd8;
  localparam logic [4:0] S_DRD  = 5'd9;
  localparam logic [4:0] S_DWR  = 5'd10;
  localparam logic [4:0] S_CLS  = 5'd11;
  localparam logic [4:0] S_BCD  = 5'd12;
  localparam logic [4:0] S_STR  = 5'd13;
  localparam logic [4:0] S_STW  = 5'd14;
  localparam logic [4:0] S_LDR  = 5'd15;
  localparam logic [4:0] S_LDW  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]  state;
  logic [11:0] cnt;
  logic [12:0] pc;
  logic [11:0] idx;
  logic [3:0]  sp;
  logic [12:0] stack [STACK_DEPTH];
  logic [7:0]  dt, st;
  logic [1:0]  halt;
  logic [15:0] last_op;
  logic [7:0]  hi, vx, vy_r, rnd;
  logic [15:0] keys;
  logic        flag, hit;
  logic [7:0]  rd_byte;
  logic [63:0] row;
  logic        drew_r, snd;

  logic        mem_we, fb_we, v_we;
  logic [11:0] mem_addr;
  logic [4:0]  fb_addr;
  logic [3:0]  v_addr;
  logic [7:0]  mem_wd, v_wd, mem_q, v_q;
  logic [63:0] fb_wd, fb_q;

  logic [3:0]  grp, x, n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [8:0]  sum;
  logic [12:0] ix_sum;
  logic        alu_we, alu_fwe, alu_flag, ill, key_x;
  logic [7:0]  alu_val;
  logic [63:0] smask;
  logic        hit_n;

  assign grp = last_op[15:12];
  assign x   = last_op[11:8];
  assign n   = last_op[3:0];
  assign kk  = last_op[7:0];
  assign nnn = last_op[11:0];
  assign sum = {1'b0, vx} + {1'b0, v_q};
  assign ix_sum = {1'b0, idx} + {5'd0, vx};
  assign key_x  = (vx[7:4] == 4'd0) && keys[vx[3:0]];
  assign smask  = rotr64({mem_q, 56'd0}, vx[5:0]);
  assign hit_n  = hit | (|(fb_q & smask));

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .q(mem_q)
  );
  c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_fb (
    .clk(clk), .we(fb_we), .addr(fb_addr), .wdata(fb_wd), .q(fb_q)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .q(v_q)
  );

  // register results of the decoded instruction; v_q holds VY (V0 for BNNN)
  always_comb begin
    alu_we   = 1'b0;
    alu_fwe  = 1'b0;
    alu_flag = 1'b0;
    alu_val  = 8'd0;
    ill      = 1'b0;
    unique case (grp)
      G_SYS:  ill = !(nnn == SYS_CLS || nnn == SYS_RET);
      G_LDI:  begin alu_we = 1'b1; alu_val = kk; end
      G_ADDI: begin alu_we = 1'b1; alu_val = vx + kk; end
      G_RND:  begin alu_we = 1'b1; alu_val = rnd & kk; end
      G_ALU: begin
        alu_we = 1'b1;
        unique case (n)
          ALU_MOV: alu_val = v_q;
          ALU_OR:  alu_val = vx | v_q;
          ALU_AND: alu_val = vx & v_q;
          ALU_XOR: alu_val = vx ^ v_q;
          ALU_ADD: begin alu_val = sum[7:0]; alu_fwe = 1'b1; alu_flag = sum[8]; end
          ALU_SUB: begin alu_val = vx - v_q; alu_fwe = 1'b1; alu_flag = vx >= v_q; end
          ALU_SHR: begin alu_val = {1'b0, vx[7:1]}; alu_fwe = 1'b1; alu_flag = vx[0]; end
          ALU_SBN: begin alu_val = v_q - vx; alu_fwe = 1'b1; alu_flag = v_q >= vx; end
          ALU_SHL: begin alu_val = {vx[6:0], 1'b0}; alu_fwe = 1'b1; alu_flag = vx[7]; end
          default: begin alu_we = 1'b0; ill = 1'b1; end
        endcase
      end
      G_KEY: ill = !(kk == KK_SKP || kk == KK_SKNP);
      G_MISC: begin
        unique case (kk)
          KK_GETDT: begin alu_we = 1'b1; alu_val = dt; end
          KK_WAITK: begin alu_we = keys != 16'd0; alu_val = {4'd0, first_key(keys)}; end
          KK_SETDT, KK_SETST, KK_ADDIX, KK_FONT, KK_BCD, KK_STORE, KK_LOAD: ;
          default: ill = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = pc[11:0];
    mem_wd   = item.write_data;
    fb_we    = 1'b0;
    fb_addr  = cnt[4:0];
    fb_wd    = '0;
    v_we     = 1'b0;
    v_addr   = x;
    v_wd     = alu_val;
    unique case (state)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = cnt;
        mem_wd   = 8'd0;
        fb_we    = cnt[11:5] == 7'd0;
        v_we     = cnt[11:4] == 8'd0;
        v_addr   = cnt[3:0];
        v_wd     = 8'd0;
      end
      S_IDLE: begin
        if (start) begin
          case (item.operation)
            OP_WRITE: begin mem_we = 1'b1; mem_addr = item.address; end
            OP_READ:  mem_addr = item.address;
            OP_ROW:   fb_addr = item.display_row;
            default: ;
          endcase
        end
      end
      S_FH:  mem_addr = pc[11:0] + 12'd1;
      S_FL:  v_addr = hi[3:0];
      S_RX:  v_addr = (grp == G_JPV0) ? 4'd0 : last_op[7:4];
      S_EX:  v_we = alu_we && !(grp == G_ALU && ill);
      S_WF: begin
        v_we   = 1'b1;
        v_addr = 4'hF;
        v_wd   = {7'd0, flag};
      end
      S_DRD: begin
        mem_addr = idx + cnt;
        fb_addr  = vy_r[4:0] + cnt[4:0];
      end
      S_DWR: begin
        fb_we   = 1'b1;
        fb_addr = vy_r[4:0] + cnt[4:0];
        fb_wd   = fb_q ^ smask;
      end
      S_CLS: fb_we = 1'b1;
      S_BCD: begin
        mem_we   = 1'b1;
        mem_addr = idx + cnt;
        mem_wd   = bcd_digit(vx, cnt[1:0]);
      end
      S_STR: v_addr = cnt[3:0];
      S_STW: begin
        mem_we   = 1'b1;
        mem_addr = idx + cnt;
        mem_wd   = v_q;
      end
      S_LDR: mem_addr = idx + cnt;
      S_LDW: begin
        v_we   = 1'b1;
        v_addr = cnt[3:0];
        v_wd   = mem_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      cnt     <= '0;
      pc      <= START_ADDRESS;
      idx     <= '0;
      sp      <= '0;
      dt      <= '0;
      st      <= '0;
      halt    <= HALT_RUN;
      last_op <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 12'd1;
          if (cnt == 12'(MEM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            rd_byte <= 8'd0;
            row     <= '0;
            drew_r  <= 1'b0;
            snd     <= 1'b0;
            keys    <= item.key_state;
            rnd     <= item.random_byte;
            state   <= S_DONE;
            case (item.operation)
              OP_READ: state <= S_MRD;
              OP_ROW:  state <= S_FRD;
              OP_EXEC: begin
                if (halt == HALT_RUN) begin
                  if (pc > PC_LAST) halt <= HALT_PC;
                  else state <= S_FH;
                end
              end
              OP_TICK: begin
                if (dt != 8'd0) dt <= dt - 8'd1;
                if (st != 8'd0) begin
                  st  <= st - 8'd1;
                  snd <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_MRD: begin rd_byte <= mem_q; state <= S_DONE; end
        S_FRD: begin row <= fb_q; state <= S_DONE; end
        S_FH:  begin hi <= mem_q; state <= S_FL; end
        S_FL: begin
          last_op <= {hi, mem_q};
          pc      <= pc + 13'd2;
          state   <= S_RX;
        end
        S_RX: begin vx <= v_q; state <= S_EX; end
        S_EX: begin
          vy_r  <= v_q;
          state <= S_DONE;
          if (ill) halt <= HALT_ILLEGAL;
          unique case (grp)
            G_SYS: begin
              if (nnn == SYS_CLS) begin
                cnt   <= '0;
                state <= S_CLS;
              end else if (nnn == SYS_RET) begin
                sp <= sp - 4'd1;
                pc <= stack[sp - 4'd1];
              end
            end
            G_JP: pc <= {1'b0, nnn};
            G_CALL: begin
              stack[sp] <= pc;
              sp        <= sp + 4'd1;
              pc        <= {1'b0, nnn};
            end
            G_SEI:  if (vx == kk)  pc <= pc + 13'd2;
            G_SNEI: if (vx != kk)  pc <= pc + 13'd2;
            G_SER:  if (vx == v_q) pc <= pc + 13'd2;
            G_SNER: if (vx != v_q) pc <= pc + 13'd2;
            G_LDIX: idx <= nnn;
            G_JPV0: pc <= {5'd0, v_q} + {1'b0, nnn};
            G_ALU: begin
              if (alu_fwe) begin
                flag  <= alu_flag;
                state <= S_WF;
              end
            end
            G_DRW: begin
              drew_r <= 1'b1;
              cnt    <= '0;
              hit    <= 1'b0;
              if (n == 4'd0) begin
                flag  <= 1'b0;
                state <= S_WF;
              end else begin
                state <= S_DRD;
              end
            end
            G_KEY: begin
              if ((kk == KK_SKP && key_x) || (kk == KK_SKNP && !key_x)) pc <= pc + 13'd2;
            end
            G_MISC: begin
              case (kk)
                KK_WAITK: if (keys == 16'd0) pc <= pc - 13'd2;
                KK_SETDT: dt <= vx;
                KK_SETST: st <= vx;
                KK_ADDIX: begin
                  idx   <= ix_sum[11:0];
                  flag  <= ix_sum[12];
                  state <= S_WF;
                end
                KK_FONT: idx <= {2'd0, vx, 2'd0} + {4'd0, vx};
                KK_BCD:   begin cnt <= '0; state <= S_BCD; end
                KK_STORE: begin cnt <= '0; state <= S_STR; end
                KK_LOAD:  begin cnt <= '0; state <= S_LDR; end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_WF:  state <= S_DONE;
        S_DRD: state <= S_DWR;
        S_DWR: begin
          hit <= hit_n;
          if (cnt[3:0] + 4'd1 == n) begin
            flag  <= hit_n;
            state <= S_WF;
          end else begin
            cnt   <= cnt + 12'd1;
            state <= S_DRD;
          end
        end
        S_CLS: begin
          cnt <= cnt + 12'd1;
          if (cnt[4:0] == 5'(SCREEN_H - 1)) state <= S_DONE;
        end
        S_BCD: begin
          cnt <= cnt + 12'd1;
          if (cnt[1:0] == 2'd2) state <= S_DONE;
        end
        S_STR: state <= S_STW;
        S_LDR: state <= S_LDW;
        S_STW, S_LDW: begin
          if (cnt[3:0] == x) begin
            idx   <= idx + {8'd0, x} + 12'd1;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 12'd1;
            state <= (state == S_STW) ? S_STR : S_LDR;
          end
        end
        S_DONE: if (ack) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = state == S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    result.program_counter = pc;
    result.last_opcode     = last_op;
    result.read_byte       = rd_byte;
    result.row_pixels      = row;
    result.drew            = drew_r;
    result.sound_on        = snd;
    result.halt_cause      = halt;
  end

endmodule

FILE: rtl/core/chip8_instruction_core.sv
// CHIP-8 interpreter core. One item per handshake: memory write/read, execute one
// instruction, timer tick, or display row read; every item gives exactly one result.
// After reset the core zeroes main memory, the display and the registers, with
// in_ready low. All state sits in single-port RAMs (memory, display, V registers)
// with one access each per cycle. A result waits in an output register, so the
// next item is taken while it is pending. The font is not built in: load it with
// memory writes at address 0.
module chip8_instruction_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  input  logic [15:0] key_state,
  input  logic [7:0]  random_byte,
  input  logic [4:0]  display_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] program_counter,
  output logic [15:0] last_opcode,
  output logic [7:0]  read_byte,
  output logic [63:0] row_pixels,
  output logic        drew,
  output logic        sound_on,
  output logic [1:0]  halt_cause
);
  import c8_pkg::*;

  item_t   item;
  result_t result;
  logic    idle, done, ack;

  assign item.operation   = operation;
  assign item.address     = address;
  assign item.write_data  = write_data;
  assign item.key_state   = key_state;
  assign item.random_byte = random_byte;
  assign item.display_row = display_row;

  assign in_ready = idle;
  assign ack      = done && (!out_valid || out_ready);

  c8_exec u_exec (
    .clk(clk), .rst(rst), .start(in_valid && idle), .item(item), .ack(ack),
    .idle(idle), .done(done), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      program_counter <= result.program_counter;
      last_opcode     <= result.last_opcode;
      read_byte       <= result.read_byte;
      row_pixels      <= result.row_pixels;
      drew            <= result.drew;
      sound_on        <= result.sound_on;
      halt_cause      <= result.halt_cause;
    end
  end

endmodule

FILE: rtl/core/c8_checker.sv
module c8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  operation,
  input logic [11:0] address,
  input logic [7:0]  write_data,
  input logic [15:0] key_state,
  input logic [7:0]  random_byte,
  input logic [4:0]  display_row,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] program_counter,
  input logic [15:0] last_opcode,
  input logic [7:0]  read_byte,
  input logic [63:0] row_pixels,
  input logic        drew,
  input logic        sound_on,
  input logic [1:0]  halt_cause
);

  // memory clearing after reset keeps the input closed
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(program_counter) && $stable(halt_cause))
    else $error("pending result changed");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> halt_cause != 2'd3)
    else $error("bad halt cause");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && drew |-> read_byte == 8'd0 && row_pixels == 64'd0 && !sound_on)
    else $error("draw result carries other item fields");

  // one result per accepted item: no new item while an earlier one is still in work
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

endmodule

bind chip8_instruction_core c8_checker u_c8_checker (.*);
